// File: rtl/core/btn_pkg.sv
// ----------------------------------------------------------------------------
// btn_pkg: shared types and character classes for the text normalizer
// beat payload structs, code point constants and classification functions
// ----------------------------------------------------------------------------
package btn_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] CpReplacement = 21'h00FFFD;
  localparam logic [CpWidth-1:0] CpTimes       = 21'h0000D7;
  localparam logic [CpWidth-1:0] CpBom         = 21'h00FEFF;
  localparam logic [CpWidth-1:0] CaseOffset    = 21'h000020;
  localparam logic [7:0]         FoldKeep      = 8'h00;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       text_last;
  } in_beat_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               has_code_point;
    logic               word_start;
    logic               text_end;
  } out_beat_t;

  function automatic logic in_rng(logic [CpWidth-1:0] c, logic [CpWidth-1:0] lo,
                                  logic [CpWidth-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_drop_control(logic [CpWidth-1:0] c);
    logic keep_ws;
    keep_ws = (c == 21'h09) || (c == 21'h0A) || (c == 21'h0D);
    return !keep_ws && ((c < 21'h20) || (c == 21'h7F) || in_rng(c, 21'h80, 21'h9F) ||
           in_rng(c, 21'h200B, 21'h200F) || in_rng(c, 21'h202A, 21'h202E) ||
           (c == CpBom));
  endfunction

  function automatic logic is_space(logic [CpWidth-1:0] c);
    return (c == 21'h20) || (c == 21'h09) || (c == 21'h0A) || (c == 21'h0D) ||
           (c == 21'h00A0) || (c == 21'h1680) || in_rng(c, 21'h2000, 21'h200A) ||
           (c == 21'h2028) || (c == 21'h2029) || (c == 21'h202F) ||
           (c == 21'h205F) || (c == 21'h3000);
  endfunction

  function automatic logic is_ideograph(logic [CpWidth-1:0] c);
    return in_rng(c, 21'h4E00, 21'h9FFF) || in_rng(c, 21'h3400, 21'h4DBF) ||
           in_rng(c, 21'h20000, 21'h2A6DF) || in_rng(c, 21'h2A700, 21'h2CEAF) ||
           in_rng(c, 21'hF900, 21'hFAFF) || in_rng(c, 21'h2F800, 21'h2FA1F);
  endfunction

  function automatic logic is_mark(logic [CpWidth-1:0] c);
    return in_rng(c, 21'h0300, 21'h036F) || in_rng(c, 21'h1AB0, 21'h1AFF) ||
           in_rng(c, 21'h1DC0, 21'h1DFF) || in_rng(c, 21'h20D0, 21'h20FF) ||
           in_rng(c, 21'hFE20, 21'hFE2F);
  endfunction

  function automatic logic is_punct(logic [CpWidth-1:0] c);
    return in_rng(c, 21'd33, 21'd47) || in_rng(c, 21'd58, 21'd64) ||
           in_rng(c, 21'd91, 21'd96) || in_rng(c, 21'd123, 21'd126) ||
           in_rng(c, 21'h2010, 21'h2027) || in_rng(c, 21'h2030, 21'h205E) ||
           in_rng(c, 21'h3001, 21'h303F) || in_rng(c, 21'hFF01, 21'hFF0F) ||
           in_rng(c, 21'hFF1A, 21'hFF20);
  endfunction

  // base letter for U+00E0..U+00FF, FoldKeep keeps the code point
  function automatic logic [7:0] latin1_fold(logic [4:0] i);
    logic [7:0] f;
    case (i) inside
      [5'h00:5'h05]: f = 8'h61;
      5'h07:         f = 8'h63;
      [5'h08:5'h0B]: f = 8'h65;
      [5'h0C:5'h0F]: f = 8'h69;
      5'h11:         f = 8'h6E;
      [5'h12:5'h16]: f = 8'h6F;
      [5'h19:5'h1C]: f = 8'h75;
      5'h1D, 5'h1F:  f = 8'h79;
      default:       f = FoldKeep;
    endcase
    return f;
  endfunction

  // base letter for U+0100..U+017F, capitals stay capital
  function automatic logic [7:0] ext_a_fold(logic [6:0] i);
    logic [7:0] f;
    case (i) inside
      7'h00, 7'h02, 7'h04:                      f = 8'h41;
      7'h01, 7'h03, 7'h05:                      f = 8'h61;
      7'h06, 7'h08, 7'h0A, 7'h0C:               f = 8'h43;
      7'h07, 7'h09, 7'h0B, 7'h0D:               f = 8'h63;
      7'h12, 7'h14, 7'h16, 7'h18, 7'h1A:        f = 8'h45;
      7'h13, 7'h15, 7'h17, 7'h19, 7'h1B:        f = 8'h65;
      7'h1E, 7'h20:                             f = 8'h47;
      7'h1F, 7'h21:                             f = 8'h67;
      7'h28, 7'h2A, 7'h2C, 7'h2E:               f = 8'h49;
      7'h29, 7'h2B, 7'h2D, 7'h2F:               f = 8'h69;
      7'h41:                                    f = 8'h4C;
      7'h42:                                    f = 8'h6C;
      7'h43, 7'h45, 7'h47:                      f = 8'h4E;
      7'h44, 7'h46, 7'h48:                      f = 8'h6E;
      7'h4C, 7'h4E, 7'h50:                      f = 8'h4F;
      7'h4D, 7'h4F, 7'h51:                      f = 8'h6F;
      7'h54, 7'h56, 7'h58:                      f = 8'h52;
      7'h55, 7'h57, 7'h59:                      f = 8'h72;
      7'h5A, 7'h5C, 7'h5E, 7'h60:               f = 8'h53;
      7'h5B, 7'h5D, 7'h5F, 7'h61:               f = 8'h73;
      7'h62, 7'h64:                             f = 8'h54;
      7'h63, 7'h65:                             f = 8'h74;
      7'h68, 7'h6A, 7'h6C, 7'h6E, 7'h70, 7'h72: f = 8'h55;
      7'h69, 7'h6B, 7'h6D, 7'h6F, 7'h71, 7'h73: f = 8'h75;
      7'h79, 7'h7B, 7'h7D:                      f = 8'h5A;
      7'h7A, 7'h7C, 7'h7E:                      f = 8'h7A;
      default:                                  f = FoldKeep;
    endcase
    return f;
  endfunction

  function automatic logic [CpWidth-1:0] fold(logic [CpWidth-1:0] c);
    logic [7:0] f;
    f = FoldKeep;
    if (in_rng(c, 21'hE0, 21'hFF)) begin
      f = latin1_fold(c[4:0]);
    end else if (in_rng(c, 21'h100, 21'h17F)) begin
      f = ext_a_fold(c[6:0]);
    end
    return (f == FoldKeep) ? c : {{(CpWidth-8){1'b0}}, f};
  endfunction

endpackage

// File: rtl/core/bert_text_normalizer_top.sv
// ----------------------------------------------------------------------------
// bert_text_normalizer_top: streaming utf-8 decoder, cleaner and word splitter
// each byte waits in the input register, its result in the result register
// throughput: one byte beat per cycle while the output is not stalled, set by
// the single decode/classify stage; a byte with no result still passes through it
// reset: asynchronous, clears decoder state, open-word flag and both valids
// ----------------------------------------------------------------------------
module bert_text_normalizer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  btn_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output btn_pkg::out_beat_t  out_data_o
);

  localparam int unsigned W = btn_pkg::CpWidth;

  // input register
  logic              in_valid_q, in_valid_d;
  btn_pkg::in_beat_t in_q;

  // result register
  logic               out_valid_q, out_valid_d;
  btn_pkg::out_beat_t out_q, out_d;

  // decoder and word state
  logic [W-1:0] part_q, part_d;
  logic [1:0]   cont_q, cont_d;
  logic         word_open_q, word_open_d;

  logic advance;   // result register can take a new value
  logic process;   // input register holds a byte that is consumed now

  assign advance    = !out_valid_q || out_ready_i;
  assign process    = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  // decode, clean, lowercase, fold and split words
  logic [7:0]   b;
  logic [W-1:0] c, lc, fc;
  logic         have, lead, emit, start;

  always_comb begin
    b      = in_q.text_byte;
    part_d = part_q;
    cont_d = cont_q;
    c      = '0;
    have   = 1'b0;
    lead   = 1'b1;

    // continuation byte of a pending sequence, or break it and re-read as lead
    if (cont_q != 2'd0) begin
      if (b[7:6] == 2'b10) begin
        lead   = 1'b0;
        part_d = {part_q[W-7:0], b[5:0]};
        cont_d = cont_q - 2'd1;
        if (cont_q == 2'd1) begin
          c    = {part_q[W-7:0], b[5:0]};
          have = 1'b1;
        end
      end else begin
        cont_d = 2'd0;
        part_d = '0;
      end
    end
    if (lead) begin
      if (!b[7]) begin
        c    = {{(W-8){1'b0}}, b};
        have = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        part_d = {{(W-5){1'b0}}, b[4:0]};
        cont_d = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        part_d = {{(W-4){1'b0}}, b[3:0]};
        cont_d = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
        part_d = {{(W-3){1'b0}}, b[2:0]};
        cont_d = 2'd3;
      end
    end
    // a sequence still pending at the end of a text is dropped
    if (in_q.text_last) begin
      cont_d = 2'd0;
      part_d = '0;
    end

    // ascii and latin-1 capitals, multiplication sign excluded
    lc = c;
    if (btn_pkg::in_rng(c, 21'h41, 21'h5A) ||
        (btn_pkg::in_rng(c, 21'hC0, 21'hDE) && (c != btn_pkg::CpTimes))) begin
      lc = c + btn_pkg::CaseOffset;
    end
    fc = btn_pkg::fold(lc);

    emit        = 1'b0;
    start       = 1'b0;
    word_open_d = word_open_q;
    if (have && (c != '0) && (c != btn_pkg::CpReplacement) &&
        !btn_pkg::is_drop_control(c)) begin
      if (btn_pkg::is_space(c)) begin
        word_open_d = 1'b0;
      end else if (btn_pkg::is_ideograph(c)) begin
        // ideographs are words of their own, emitted unfolded
        emit        = 1'b1;
        start       = 1'b1;
        word_open_d = 1'b0;
      end else if (!btn_pkg::is_mark(lc)) begin
        emit = 1'b1;
        if (btn_pkg::is_punct(fc)) begin
          start       = 1'b1;
          word_open_d = 1'b0;
        end else begin
          start       = !word_open_q;
          word_open_d = 1'b1;
        end
      end
    end
    if (in_q.text_last) begin
      word_open_d = 1'b0;
    end

    out_d.code_point     = emit ? (btn_pkg::is_ideograph(c) ? c : fc) : '0;
    out_d.has_code_point = emit;
    out_d.word_start     = emit && start;
    out_d.text_end       = in_q.text_last;
  end

  // handshake bookkeeping
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end else if (process) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      // a beat that yields nothing leaves the result register empty
      out_valid_d = process && (out_d.has_code_point || out_d.text_end);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      part_q      <= '0;
      cont_q      <= 2'd0;
      word_open_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (process) begin
        part_q      <= part_d;
        cont_q      <= cont_d;
        word_open_q <= word_open_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (process) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
